/* rtl/core/moving_average_trailing_band_macros.svh */
// Assertion macros used by the trailing band controller.
`ifndef MOVING_AVERAGE_TRAILING_BAND_MACROS_SVH
`define MOVING_AVERAGE_TRAILING_BAND_MACROS_SVH
`ifndef SYNTH
// Clocked check, off while reset is asserted.
`define MATB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("matb check failed");
// Clocked check, active during reset too.
`define MATB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("matb check failed");
`else
`define MATB_ASSERT(label, clk, rst_n, prop)
`define MATB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/core/matb_pkg.sv */
// Types and constants of the trailing band block.
package matb_pkg;
    localparam int PRICE_W   = 32;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 9;
    localparam int DAYS_W    = 8;
    localparam int BAND_W    = 16;
    localparam int IDX_W     = 6;
    localparam int FRAC_W    = 16;
    localparam int FACT_W    = 17;
    localparam int PROD_W    = PRICE_W + FACT_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIVC_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DAYS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_FRACTION = 1'b1;
    localparam logic [DAYS_W-1:0] WINDOW_RESET = 8'd20;
    localparam logic [BAND_W-1:0] BAND_RESET   = 16'd3277;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [SUM_W-1:0]   ra;
        logic [PRICE_W-1:0] rf;
        logic               sold;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic capture;
        logic clear_step;
        logic div_sum;
        logic avg_ra;
        logic avg_mean;
        logic div_diff;
        logic div_step;
        logic set_na;
        logic mul;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic warm;
        logic first;
        logic div_last;
        logic clear_done;
    } dp_status_t;
endpackage

/* rtl/core/matb_in_if.sv */
// Sample channel: valid/ready with one close price.
interface matb_in_if import matb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   series_index;
    logic [PRICE_W-1:0] close_price;
    logic               restart;

    modport source (output valid, series_index, close_price, restart, input ready);
    modport sink   (input valid, series_index, close_price, restart, output ready);
endinterface

/* rtl/core/matb_out_if.sv */
// Result channel: valid/ready with one reference level.
interface matb_out_if import matb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   series_out;
    logic [PRICE_W-1:0] reference_price;
    logic               sold_flag;
    logic               warming_up;

    modport source (output valid, series_out, reference_price, sold_flag, warming_up,
                    input ready);
    modport sink   (input valid, series_out, reference_price, sold_flag, warming_up,
                    output ready);
endinterface

/* rtl/core/matb_ram.sv */
// Generic single write port RAM with registered read.
module matb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/matb_datapath.sv */
// Datapath: config registers, series state RAM, serial divider, band multiplier.
module matb_datapath import matb_pkg::*; #(
    parameter int NUM_SERIES = 64,
    localparam int AW = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IDX_W-1:0]      series_index,
    input  logic [PRICE_W-1:0]    close_price,
    input  logic                  restart,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [IDX_W-1:0]      series_out,
    output logic [PRICE_W-1:0]    reference_price,
    output logic                  sold_flag,
    output logic                  warming_up
);
    logic [DAYS_W-1:0]  window_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PRICE_W-1:0] c_reg;
    logic               restart_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic               in_range_reg;
    entry_t             ent_reg;
    logic [DAYS_W-1:0]  rem_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [DIVC_W-1:0]  divc_reg;
    logic [PRICE_W-1:0] avg_reg;
    logic               neg_reg;
    logic [PRICE_W-1:0] na_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               up_reg;
    logic               flip_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [IDX_W-1:0]   out_series_reg;
    logic [PRICE_W-1:0] out_ref_reg;
    logic               out_sold_reg;
    logic               out_warm_reg;

    logic [12:0]        idx_wide;
    logic [AW-1:0]      addr;
    entry_t             ram_rdata;
    entry_t             new_ent;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic               warm;
    logic               first;
    logic [DAYS_W:0]    div_trial;
    logic               div_bit;
    logic [PRICE_W-1:0] mag;
    logic               c_lt_avg;
    logic [PRICE_W-1:0] mul_x;
    logic               mul_up;
    logic               mul_flip;
    logic [FACT_W-1:0]  factor;
    logic [PRICE_W:0]   scaled;
    logic [PRICE_W-1:0] band_val;
    logic [PRICE_W-1:0] new_ref;
    logic [SUM_W:0]     sum_wide;

    assign idx_wide = {7'd0, idx_reg};
    assign addr     = idx_wide[AW-1:0];
    assign warm     = ent_reg.cnt < {1'b0, days_reg};
    assign first    = ent_reg.cnt == {1'b0, days_reg};

    assign status.in_range   = in_range_reg;
    assign status.warm       = warm;
    assign status.first      = first;
    assign status.div_last   = divc_reg == DIVC_W'(1);
    assign status.clear_done = clr_addr_reg == AW'(NUM_SERIES - 1);

    // restoring divide step, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_bit   = div_trial >= {1'b0, days_reg};

    assign c_lt_avg = c_reg < avg_reg;
    assign mag      = c_lt_avg ? (avg_reg - c_reg) : (c_reg - avg_reg);

    always_comb
    begin
        mul_x    = warm ? c_reg : na_reg;
        mul_flip = 1'b0;
        if (warm)
        begin
            mul_up = 1'b0;
        end
        else if (first)
        begin
            mul_up = c_reg <= na_reg;
        end
        else if (ent_reg.sold)
        begin
            mul_flip = c_reg > ent_reg.rf;
            mul_up   = !mul_flip;
        end
        else
        begin
            mul_flip = c_reg < ent_reg.rf;
            mul_up   = mul_flip;
        end
        factor = mul_up ? (FACT_W'(65536) + FACT_W'(band_reg))
                        : (FACT_W'(65536) - FACT_W'(band_reg));
    end

    assign scaled   = prod_reg[PROD_W-1:FRAC_W];
    assign band_val = scaled[PRICE_W] ? '1 : scaled[PRICE_W-1:0];
    assign sum_wide = {1'b0, ent_reg.ra} + (SUM_W+1)'(c_reg);

    always_comb
    begin
        if (warm || first || flip_reg)
        begin
            new_ref = band_val;
        end
        else if (up_reg)
        begin
            new_ref = (band_val < ent_reg.rf) ? band_val : ent_reg.rf;
        end
        else
        begin
            new_ref = (band_val > ent_reg.rf) ? band_val : ent_reg.rf;
        end
        new_ent.rf   = new_ref;
        new_ent.sold = warm ? ent_reg.sold : up_reg;
        if (warm)
        begin
            new_ent.ra = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
        else
        begin
            new_ent.ra = SUM_W'(na_reg);
        end
        if (ent_reg.cnt < ({1'b0, days_reg} + CNT_W'(1)))
        begin
            new_ent.cnt = ent_reg.cnt + CNT_W'(1);
        end
        else
        begin
            new_ent.cnt = ent_reg.cnt;
        end
    end

    assign ram_we    = cmd.clear_step || (cmd.finish && in_range_reg);
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : addr;
    assign ram_wdata = cmd.clear_step ? '0 : new_ent;

    matb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SERIES)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RESET;
            band_reg     <= BAND_RESET;
            divc_reg     <= '0;
            clr_addr_reg <= '0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_WINDOW_DAYS)
            begin
                window_reg <= cfg_wdata[DAYS_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_BAND_FRACTION)
            begin
                band_reg <= cfg_wdata[BAND_W-1:0];
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                in_range_reg <= {7'd0, series_index} < 13'(NUM_SERIES);
            end
            if (cmd.div_sum || cmd.div_diff)
            begin
                divc_reg <= DIVC_W'(DIV_STEPS);
            end
            else if (cmd.div_step)
            begin
                divc_reg <= divc_reg - DIVC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg     <= series_index;
            c_reg       <= close_price;
            restart_reg <= restart;
            days_reg    <= (window_reg == '0) ? DAYS_W'(1) : window_reg;
        end
        if (cmd.capture)
        begin
            ent_reg <= restart_reg ? '0 : ram_rdata;
        end
        if (cmd.div_sum)
        begin
            quo_reg <= ent_reg.ra;
            rem_reg <= '0;
        end
        else if (cmd.div_diff)
        begin
            quo_reg <= SUM_W'(mag);
            rem_reg <= '0;
            neg_reg <= c_lt_avg;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], div_bit};
            rem_reg <= div_bit ? DAYS_W'(div_trial - {1'b0, days_reg})
                               : div_trial[DAYS_W-1:0];
        end
        if (cmd.avg_ra)
        begin
            avg_reg <= (ent_reg.ra[SUM_W-1:PRICE_W] != '0) ? '1 : ent_reg.ra[PRICE_W-1:0];
        end
        else if (cmd.avg_mean)
        begin
            avg_reg <= (quo_reg[SUM_W-1:PRICE_W] != '0) ? '1 : quo_reg[PRICE_W-1:0];
        end
        if (cmd.set_na)
        begin
            na_reg <= neg_reg ? (avg_reg - quo_reg[PRICE_W-1:0])
                              : (avg_reg + quo_reg[PRICE_W-1:0]);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mul_x) * PROD_W'(factor);
            up_reg   <= mul_up;
            flip_reg <= mul_flip;
        end
        if (cmd.finish)
        begin
            out_series_reg <= idx_reg;
            out_ref_reg    <= in_range_reg ? new_ent.rf : '0;
            out_sold_reg   <= in_range_reg && new_ent.sold;
            out_warm_reg   <= in_range_reg && warm;
        end
    end

    assign series_out      = out_series_reg;
    assign reference_price = out_ref_reg;
    assign sold_flag       = out_sold_reg;
    assign warming_up      = out_warm_reg;
endmodule

/* rtl/core/matb_ctrl.sv */
// Controller: sequences clear pass, state read, divides, multiply and writeback.
`include "moving_average_trailing_band_macros.svh"
module matb_ctrl import matb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_CAPT  = 4'd3;
    localparam logic [3:0] ST_DEC   = 4'd4;
    localparam logic [3:0] ST_DIV1  = 4'd5;
    localparam logic [3:0] ST_AVGM  = 4'd6;
    localparam logic [3:0] ST_DIFF  = 4'd7;
    localparam logic [3:0] ST_DIV2  = 4'd8;
    localparam logic [3:0] ST_NA    = 4'd9;
    localparam logic [3:0] ST_MUL   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       sample_fire;
    logic       slot_free;

    assign in_ready    = state_reg == ST_IDLE;
    assign sample_fire = in_valid && in_ready;
    assign slot_free   = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = status.in_range ? ST_CAPT : ST_FIN;
            end
            ST_CAPT:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC:
            begin
                if (status.warm)
                begin
                    state_next = ST_MUL;
                end
                else if (status.first)
                begin
                    cmd.div_sum = 1'b1;
                    state_next  = ST_DIV1;
                end
                else
                begin
                    cmd.avg_ra = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_AVGM;
                end
            end
            ST_AVGM:
            begin
                cmd.avg_mean = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.div_diff = 1'b1;
                state_next   = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_NA;
                end
            end
            ST_NA:
            begin
                cmd.set_na = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MATB_ASSERT(a_accept_only_idle, clk, rst_n, (sample_fire |-> state_reg == ST_IDLE))
    `MATB_ASSERT(a_div_exit, clk, rst_n, (state_reg == ST_DIV2 && status.div_last |=> state_reg == ST_NA))
    `MATB_ASSERT(a_finish_shows, clk, rst_n, (cmd.finish |=> out_valid_reg))
endmodule

/* rtl/core/moving_average_trailing_band.sv */
// Trailing band reference per price series. One sample transaction in, one result
// transaction out, one sample in flight at a time. A steady sample runs the 40-step
// serial divider (one quotient bit per cycle) that forms (close - avg) / window_days;
// the sample that ends the warm-up runs that divider twice (sum / window_days first),
// and a warm-up sample skips it. The 32x17 band multiply has its own state. After
// reset a clearing pass writes every series entry of the state RAM to zero, one per
// cycle, with sample ready low; configuration writes are taken all the time. A
// finished result sits in an output register, so the next sample is taken while it
// waits.
module moving_average_trailing_band import matb_pkg::*; #(
    parameter int NUM_SERIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    matb_in_if.sink               sample,
    matb_out_if.source            result
);
    // command / status bundle between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    matb_datapath #(
        .NUM_SERIES (NUM_SERIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .series_index    (sample.series_index),
        .close_price     (sample.close_price),
        .restart         (sample.restart),
        .cmd             (cmd),
        .status          (status),
        .series_out      (result.series_out),
        .reference_price (result.reference_price),
        .sold_flag       (result.sold_flag),
        .warming_up      (result.warming_up)
    );

    // sequencer owns both handshakes; payload stays in the datapath
    matb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );
endmodule

/* tb/tb_pkg_note.sv */
// Testbench types for the trailing band block.
package tb_matb_pkg;
    import matb_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   series;
        logic [PRICE_W-1:0] level;
        logic               sold;
        logic               warm;
    } band_result_t;
endpackage

/* tb/tb.sv */
// Self-checking testbench of the trailing band block with an internal predictor.
module tb;
    import matb_pkg::*;
    import tb_matb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_DAYS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    matb_in_if  sample_ch ();
    matb_out_if result_ch ();

    moving_average_trailing_band #(.NUM_SERIES(64)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .sample(sample_ch.sink), .result(result_ch.source)
    );

    always #5 clk = ~clk;

    // predictor state, one entry per series
    logic [8:0]  cnt_q  [64];
    logic [39:0] avg_q  [64];
    logic [31:0] ref_q  [64];
    logic        sold_q [64];
    logic [7:0]  win_cfg;
    logic [15:0] band_cfg;

    band_result_t pending_levels[$];
    int errors = 0;
    int checked = 0;
    int sent = 0;
    int long_stall_pct = 0;

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] shade_down(logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * (64'd65536 - {48'd0, band_cfg});
        return p[47:16];
    endfunction

    function automatic logic [31:0] shade_up(logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * (64'd65536 + {48'd0, band_cfg});
        return clamp32(p >> 16);
    endfunction

    // avg + (close - avg) / days, quotient truncated toward zero
    function automatic logic [31:0] ema_move(logic [31:0] a, logic [31:0] c, int unsigned d);
        longint diff, q;
        diff = longint'({32'd0, c}) - longint'({32'd0, a});
        q = diff / longint'(d);
        return 32'(longint'({32'd0, a}) + q);
    endfunction

    function automatic band_result_t predict_level(logic [5:0] s, logic [31:0] c, logic rs);
        band_result_t r;
        int unsigned d;
        logic [8:0] n;
        logic [40:0] sum;
        logic [31:0] na, rf, nr;
        d = (win_cfg == 0) ? 1 : win_cfg;
        r.series = s;
        r.warm = 1'b0;
        if (rs)
        begin
            cnt_q[s] = '0; avg_q[s] = '0; ref_q[s] = '0; sold_q[s] = 1'b0;
        end
        n = cnt_q[s];
        if (n < d)
        begin
            sum = {1'b0, avg_q[s]} + {9'd0, c};
            avg_q[s] = sum[40] ? 40'hFF_FFFF_FFFF : sum[39:0];
            ref_q[s] = shade_down(c);
            r.warm = 1'b1;
        end
        else if (n == d)
        begin
            na = ema_move(clamp32({24'd0, avg_q[s]} / d), c, d);
            avg_q[s] = {8'd0, na};
            sold_q[s] = (c <= na);
            ref_q[s] = (c <= na) ? shade_up(na) : shade_down(na);
        end
        else
        begin
            rf = ref_q[s];
            na = ema_move(clamp32({24'd0, avg_q[s]}), c, d);
            avg_q[s] = {8'd0, na};
            if (sold_q[s])
            begin
                if (c > rf)
                begin
                    sold_q[s] = 1'b0; ref_q[s] = shade_down(na);
                end
                else
                begin
                    nr = shade_up(na); ref_q[s] = (nr < rf) ? nr : rf;
                end
            end
            else
            begin
                if (c < rf)
                begin
                    sold_q[s] = 1'b1; ref_q[s] = shade_up(na);
                end
                else
                begin
                    nr = shade_down(na); ref_q[s] = (nr > rf) ? nr : rf;
                end
            end
        end
        if (n < d + 1) cnt_q[s] = n + 9'd1;
        r.level = ref_q[s];
        r.sold = sold_q[s];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // send one sample transaction, predicting at acceptance; valid stays up
    // for a back-to-back follower and is dropped before a gap or by drain()
    task automatic send_sample(logic [5:0] s, logic [31:0] c, logic rs, bit may_idle = 1);
        int g;
        g = may_idle ? gap_len() : 0;
        if (g > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.series_index <= s;
        sample_ch.close_price <= c;
        sample_ch.restart <= rs;
        do @(posedge clk); while (!sample_ch.ready);
        pending_levels.push_back(predict_level(s, c, rs));
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_DAYS) win_cfg = v[7:0];
        else band_cfg = v;
    endtask

    // block is idle once every result is back; one sample in flight at most
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random back-pressure, compare against oldest prediction
    always @(posedge clk)
    begin
        band_result_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_levels.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result series %0d", result_ch.series_out);
            end
            else
            begin
                e = pending_levels.pop_front();
                checked++;
                if (e.series !== result_ch.series_out || e.level !== result_ch.reference_price
                    || e.sold !== result_ch.sold_flag || e.warm !== result_ch.warming_up)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp s%0d ref %h sold %b warm %b, got s%0d ref %h sold %b warm %b",
                                 e.series, e.level, e.sold, e.warm, result_ch.series_out,
                                 result_ch.reference_price, result_ch.sold_flag,
                                 result_ch.warming_up);
                end
            end
        end
        result_ch.ready <= ($urandom_range(99) >= long_stall_pct);
    end

    task automatic test_warmup_edges();
        write_reg(CFG_WINDOW_DAYS, 16'd3);
        write_reg(CFG_BAND_FRACTION, 16'd0);
        send_sample(6'd0, 32'd0, 1'b1);
        send_sample(6'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(6'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(6'd0, 32'd0, 1'b0);
        send_sample(6'd0, 32'hFFFF_FFFF, 1'b0);
        drain();
        write_reg(CFG_WINDOW_DAYS, 16'd0);   // zero window acts as one
        write_reg(CFG_BAND_FRACTION, 16'hFFFF);
        send_sample(6'd63, 32'hFFFF_FFFF, 1'b1);
        send_sample(6'd63, 32'h0001_0000, 1'b0);
        send_sample(6'd63, 32'hFFFF_FFFF, 1'b0);
        send_sample(6'd63, 32'd0, 1'b0);
        drain();
    endtask

    task automatic test_window_change();
        // long window sums, then shrink: sum read as average and clamped
        write_reg(CFG_WINDOW_DAYS, 16'd255);
        for (int i = 0; i < 6; i++) send_sample(6'd5, 32'hFFFF_FFFF, i == 0);
        drain();
        write_reg(CFG_WINDOW_DAYS, 16'd2);
        send_sample(6'd5, 32'h0100_0000, 1'b0);
        send_sample(6'd5, 32'h0000_0001, 1'b0);
        send_sample(6'd5, 32'hFFFF_0000, 1'b0);
        drain();
    endtask

    task automatic test_random_series(int count);
        logic [31:0] base [64];
        int s;
        for (int i = 0; i < 64; i++) base[i] = $urandom;
        for (int i = 0; i < count; i++)
        begin
            if (i % 250 == 249)
            begin
                // hold off until all results are back, then re-configure
                drain();
                case ($urandom_range(3))
                    0: write_reg(CFG_WINDOW_DAYS, 16'($urandom_range(5, 1)));
                    1: write_reg(CFG_WINDOW_DAYS, 16'd255);
                    default: write_reg(CFG_WINDOW_DAYS, 16'($urandom_range(12, 2)));
                endcase
                write_reg(CFG_BAND_FRACTION, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
                long_stall_pct = ($urandom_range(2) == 0) ? 0 : 30;
            end
            s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
            if ($urandom_range(9) == 0)
                base[s] = $urandom;
            else
                base[s] = base[s] + 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            send_sample(6'(s), ($urandom_range(19) == 0) ? $urandom : base[s],
                        $urandom_range(40) == 0, $urandom_range(4) != 0);
        end
        drain();
    endtask

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.series_index = '0;
        sample_ch.close_price = '0;
        sample_ch.restart = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            cnt_q[i] = '0; avg_q[i] = '0; ref_q[i] = '0; sold_q[i] = 1'b0;
        end
        win_cfg = WINDOW_RESET;
        band_cfg = BAND_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_warmup_edges();
        test_window_change();
        write_reg(CFG_WINDOW_DAYS, 16'd4);
        write_reg(CFG_BAND_FRACTION, 16'd3277);
        test_random_series(1730);
        repeat (200) @(posedge clk);
        $display("Sent %0d samples over 64 series, %0d results checked,", sent, checked);
        $display("window and band swept including zero, one and full scale.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/matb_pkg.sv
rtl/core/matb_in_if.sv
rtl/core/matb_out_if.sv
rtl/core/matb_ram.sv
rtl/core/matb_datapath.sv
rtl/core/matb_ctrl.sv
rtl/core/moving_average_trailing_band.sv
tb/tb_pkg_note.sv
tb/tb.sv
